FILE: rtl/core/location_expression_stack_machine_assert.svh
// ----------------------------------------------------------------------------
// location expression stack machine assertion macros
// concurrent checks that compile away for synthesis
// ----------------------------------------------------------------------------
`ifndef LOCATION_EXPRESSION_STACK_MACHINE_ASSERT_SVH
`define LOCATION_EXPRESSION_STACK_MACHINE_ASSERT_SVH
`ifndef SYNTHESIS
`define LESM_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
		else $error("assertion failed");
`define LESM_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("assertion failed");
`else
`define LESM_ASSERT(lbl, clk, rstn, prop)
`define LESM_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`endif
`endif

FILE: rtl/core/lesm_pkg.sv
// ----------------------------------------------------------------------------
// lesm_pkg
// shared constants and types of the location expression stack machine
// ----------------------------------------------------------------------------
package lesm_pkg;

	localparam int STACK_DEPTH_DEF = 16;
	localparam int REG_COUNT       = 32;

	localparam logic [1:0] OPER_EXPR  = 2'd0;
	localparam logic [1:0] OPER_REPLY = 2'd1;
	localparam logic [1:0] OPER_REGWR = 2'd2;

	localparam logic [1:0] KIND_READ = 2'd0;
	localparam logic [1:0] KIND_LOC  = 2'd1;
	localparam logic [1:0] KIND_ERR  = 2'd2;

	localparam logic [2:0] ERR_NONE   = 3'd0;
	localparam logic [2:0] ERR_UNDER  = 3'd1;
	localparam logic [2:0] ERR_OVER   = 3'd2;
	localparam logic [2:0] ERR_UNSUP  = 3'd3;
	localparam logic [2:0] ERR_BADREG = 3'd4;
	localparam logic [2:0] ERR_DIVZ   = 3'd5;
	localparam logic [2:0] ERR_READ   = 3'd6;
	localparam logic [2:0] ERR_EMPTY  = 3'd7;

	localparam logic [7:0] OP_ADDR        = 8'h03;
	localparam logic [7:0] OP_DEREF       = 8'h06;
	localparam logic [7:0] OP_CONST1U     = 8'h08;
	localparam logic [7:0] OP_CONST1S     = 8'h09;
	localparam logic [7:0] OP_CONST2U     = 8'h0a;
	localparam logic [7:0] OP_CONST2S     = 8'h0b;
	localparam logic [7:0] OP_CONST4U     = 8'h0c;
	localparam logic [7:0] OP_CONST4S     = 8'h0d;
	localparam logic [7:0] OP_CONST8U     = 8'h0e;
	localparam logic [7:0] OP_CONST8S     = 8'h0f;
	localparam logic [7:0] OP_DUP         = 8'h12;
	localparam logic [7:0] OP_DROP        = 8'h13;
	localparam logic [7:0] OP_OVER        = 8'h14;
	localparam logic [7:0] OP_PICK        = 8'h15;
	localparam logic [7:0] OP_SWAP        = 8'h16;
	localparam logic [7:0] OP_ROT         = 8'h17;
	localparam logic [7:0] OP_ABS         = 8'h19;
	localparam logic [7:0] OP_AND         = 8'h1a;
	localparam logic [7:0] OP_DIV         = 8'h1b;
	localparam logic [7:0] OP_MINUS       = 8'h1c;
	localparam logic [7:0] OP_MOD         = 8'h1d;
	localparam logic [7:0] OP_MUL         = 8'h1e;
	localparam logic [7:0] OP_NEG         = 8'h1f;
	localparam logic [7:0] OP_NOT         = 8'h20;
	localparam logic [7:0] OP_OR          = 8'h21;
	localparam logic [7:0] OP_PLUS        = 8'h22;
	localparam logic [7:0] OP_PLUS_UCONST = 8'h23;
	localparam logic [7:0] OP_SHL         = 8'h24;
	localparam logic [7:0] OP_SHR         = 8'h25;
	localparam logic [7:0] OP_SHRA        = 8'h26;
	localparam logic [7:0] OP_XOR         = 8'h27;
	localparam logic [7:0] OP_EQ          = 8'h29;
	localparam logic [7:0] OP_GE          = 8'h2a;
	localparam logic [7:0] OP_GT          = 8'h2b;
	localparam logic [7:0] OP_LE          = 8'h2c;
	localparam logic [7:0] OP_LT          = 8'h2d;
	localparam logic [7:0] OP_NE          = 8'h2e;
	localparam logic [7:0] OP_SKIP        = 8'h2f;
	localparam logic [7:0] OP_LIT_LO      = 8'h30;
	localparam logic [7:0] OP_LIT_HI      = 8'h4f;
	localparam logic [7:0] OP_REG_LO      = 8'h50;
	localparam logic [7:0] OP_REG_HI      = 8'h6f;
	localparam logic [7:0] OP_BREG_LO     = 8'h70;
	localparam logic [7:0] OP_BREG_HI     = 8'h8f;
	localparam logic [7:0] OP_REGX        = 8'h90;
	localparam logic [7:0] OP_BREGX       = 8'h92;
	localparam logic [7:0] OP_DEREF_SIZE  = 8'h94;
	localparam logic [7:0] OP_NOP         = 8'h96;

	typedef enum logic [3:0] {
		CLS_PUSH,
		CLS_UNARY,
		CLS_BIN,
		CLS_SWAP,
		CLS_ROT,
		CLS_DROP,
		CLS_NOP,
		CLS_DEREF,
		CLS_UNSUP
	} cls_t;

endpackage

FILE: rtl/core/lesm_in_if.sv
// ----------------------------------------------------------------------------
// lesm_in_if
// input channel: operator, read reply or register file write
// ----------------------------------------------------------------------------
interface lesm_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  operation;
	logic [7:0]  opcode;
	logic [63:0] operand_a;
	logic [63:0] operand_b;
	logic        last_op;
	logic [31:0] read_data;
	logic        read_ok;

	modport source (
		output valid, operation, opcode, operand_a, operand_b, last_op, read_data, read_ok,
		input  ready
	);
	modport sink (
		input  valid, operation, opcode, operand_a, operand_b, last_op, read_data, read_ok,
		output ready
	);
endinterface

FILE: rtl/core/lesm_out_if.sv
// ----------------------------------------------------------------------------
// lesm_out_if
// result channel: read request, final location or error
// ----------------------------------------------------------------------------
interface lesm_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [63:0] read_address;
	logic [2:0]  read_bytes;
	logic [31:0] location;
	logic [2:0]  error_code;

	modport source (
		output valid, kind, read_address, read_bytes, location, error_code,
		input  ready
	);
	modport sink (
		input  valid, kind, read_address, read_bytes, location, error_code,
		output ready
	);
endinterface

FILE: rtl/core/lesm_ram.sv
// ----------------------------------------------------------------------------
// lesm_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module lesm_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

FILE: rtl/core/location_expression_stack_machine.sv
// operators pass through the sequencer states fetch (when stack operands are needed),
// execute, multiply or divide, and write back; dereference and reply finish on the transfer
// throughput: one item at a time; the next transfer can follow once the sequencer is
// back in idle and the result register is free or is being drained in that cycle
// reset: stack empty, register file zero, no pending read; no clearing pass
// ----------------------------------------------------------------------------
// location_expression_stack_machine
// dwarf location expression evaluator on a 64-bit value stack
// ----------------------------------------------------------------------------
`include "location_expression_stack_machine_assert.svh"

module location_expression_stack_machine #(
	parameter int STACK_DEPTH = lesm_pkg::STACK_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	lesm_in_if.sink    in_ch,
	lesm_out_if.source out_ch
);
	localparam int AW = $clog2(STACK_DEPTH);
	localparam int CW = $clog2(STACK_DEPTH + 1);

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_FETCH = 7'b0000010,
		S_EXEC  = 7'b0000100,
		S_MUL   = 7'b0001000,
		S_DIV   = 7'b0010000,
		S_DFIN  = 7'b0100000,
		S_WR    = 7'b1000000
	} state_t;

	state_t          state_q, state_d;
	logic [CW-1:0]   count_q, count_d;
	logic [63:0]     top_q, top_d;
	logic            await_q, await_d;
	logic            pfin_q, pfin_d;
	logic [2:0]      psize_q, psize_d;
	logic [5:0]      cnt_q, cnt_d;
	logic            out_valid_q, out_valid_d;
	logic [1:0]      okind_q, okind_d;
	logic [63:0]     oaddr_q, oaddr_d;
	logic [2:0]      obytes_q, obytes_d;
	logic [31:0]     oloc_q, oloc_d;
	logic [2:0]      oerr_q, oerr_d;

	logic [7:0]      opc_q, opc_d;
	logic [63:0]     a_q, a_d;
	logic [63:0]     b_q, b_d;
	logic            last_q, last_d;
	lesm_pkg::cls_t  cls_q, cls_d;
	logic [1:0]      need_q, need_d;
	logic [63:0]     x_q, x_d;
	logic [63:0]     z_q, z_d;
	logic [63:0]     res_q, res_d;
	logic [63:0]     acc_q, acc_d;
	logic [63:0]     prod_q, prod_d;
	logic [63:0]     quo_q, quo_d;
	logic [63:0]     rem_q, rem_d;
	logic [63:0]     dvs_q, dvs_d;

	logic [31:0]     rf_q [lesm_pkg::REG_COUNT];
	logic            rf_we;

	logic            ram_we;
	logic [AW-1:0]   ram_waddr, ram_raddr;
	logic [63:0]     ram_wdata, ram_rdata;

	logic            in_acc;
	lesm_pkg::cls_t  dec_cls;
	logic [1:0]      dec_need;
	logic [2:0]      dec_err;
	logic [CW-1:0]   dec_min;
	logic            dec_pick, dec_push;
	logic [2:0]      dec_bytes;
	logic [4:0]      ridx;
	logic [63:0]     rval;
	logic [63:0]     alu;
	logic [63:0]     reply_val;
	logic [31:0]     mul_a, mul_b;
	logic [64:0]     div_t;
	logic            div_ge;
	logic [1:0]      nwr;
	logic            slt_xy, slt_yx;

	lesm_ram #(.WIDTH(64), .DEPTH(STACK_DEPTH)) u_stack (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign in_acc = in_ch.valid && in_ch.ready;
	assign in_ch.ready = (state_q == S_IDLE) && (!out_valid_q || out_ch.ready);
	assign out_ch.valid = out_valid_q;
	assign out_ch.kind = okind_q;
	assign out_ch.read_address = oaddr_q;
	assign out_ch.read_bytes = obytes_q;
	assign out_ch.location = oloc_q;
	assign out_ch.error_code = oerr_q;

	// operator decode and error checks
	always_comb begin
		dec_cls = lesm_pkg::CLS_UNSUP;
		dec_need = 2'd0;
		dec_min = '0;
		dec_pick = 1'b0;
		dec_push = 1'b0;
		dec_bytes = 3'd4;
		unique case (in_ch.opcode) inside
			lesm_pkg::OP_ADDR, lesm_pkg::OP_CONST1U, lesm_pkg::OP_CONST1S,
			lesm_pkg::OP_CONST2U, lesm_pkg::OP_CONST2S, lesm_pkg::OP_CONST4U,
			lesm_pkg::OP_CONST4S, lesm_pkg::OP_CONST8U, lesm_pkg::OP_CONST8S,
			[lesm_pkg::OP_LIT_LO:lesm_pkg::OP_LIT_HI],
			[lesm_pkg::OP_REG_LO:lesm_pkg::OP_REG_HI],
			[lesm_pkg::OP_BREG_LO:lesm_pkg::OP_BREG_HI],
			lesm_pkg::OP_REGX, lesm_pkg::OP_BREGX: begin
				dec_cls = lesm_pkg::CLS_PUSH;
			end
			lesm_pkg::OP_DUP: begin
				dec_cls = lesm_pkg::CLS_PUSH;
				dec_min = CW'(1);
			end
			lesm_pkg::OP_OVER: begin
				dec_cls = lesm_pkg::CLS_PUSH;
				dec_need = 2'd1;
				dec_min = CW'(2);
			end
			lesm_pkg::OP_PICK: begin
				dec_cls = lesm_pkg::CLS_PUSH;
				dec_need = 2'd1;
				dec_pick = 1'b1;
			end
			lesm_pkg::OP_AND, lesm_pkg::OP_DIV, lesm_pkg::OP_MINUS, lesm_pkg::OP_MOD,
			lesm_pkg::OP_MUL, lesm_pkg::OP_OR, lesm_pkg::OP_PLUS, lesm_pkg::OP_SHL,
			lesm_pkg::OP_SHR, lesm_pkg::OP_SHRA, lesm_pkg::OP_XOR, lesm_pkg::OP_EQ,
			lesm_pkg::OP_GE, lesm_pkg::OP_GT, lesm_pkg::OP_LE, lesm_pkg::OP_LT,
			lesm_pkg::OP_NE: begin
				dec_cls = lesm_pkg::CLS_BIN;
				dec_need = 2'd1;
				dec_min = CW'(2);
			end
			lesm_pkg::OP_SKIP, lesm_pkg::OP_NOP: begin
				dec_cls = lesm_pkg::CLS_NOP;
			end
			lesm_pkg::OP_DEREF: begin
				dec_cls = lesm_pkg::CLS_DEREF;
				dec_min = CW'(1);
			end
			lesm_pkg::OP_DEREF_SIZE: begin
				dec_min = CW'(1);
				dec_bytes = in_ch.operand_a[2:0];
				if (!(|in_ch.operand_a[63:3]) && (in_ch.operand_a[2:0] != 3'd0)
					&& (in_ch.operand_a[2:0] <= 3'd4)) begin
					dec_cls = lesm_pkg::CLS_DEREF;
				end
			end
			lesm_pkg::OP_DROP: begin
				dec_cls = lesm_pkg::CLS_DROP;
				dec_need = 2'd1;
				dec_min = CW'(1);
			end
			lesm_pkg::OP_ABS, lesm_pkg::OP_NEG, lesm_pkg::OP_NOT,
			lesm_pkg::OP_PLUS_UCONST: begin
				dec_cls = lesm_pkg::CLS_UNARY;
				dec_min = CW'(1);
			end
			lesm_pkg::OP_SWAP: begin
				dec_cls = lesm_pkg::CLS_SWAP;
				dec_need = 2'd1;
				dec_min = CW'(2);
			end
			lesm_pkg::OP_ROT: begin
				dec_cls = lesm_pkg::CLS_ROT;
				dec_need = 2'd2;
				dec_min = CW'(3);
			end
			default: begin
				dec_cls = lesm_pkg::CLS_UNSUP;
			end
		endcase
		dec_push = (dec_cls == lesm_pkg::CLS_PUSH);

		if (dec_cls == lesm_pkg::CLS_UNSUP) begin
			dec_err = lesm_pkg::ERR_UNSUP;
		end else if ((count_q < dec_min)
			|| (dec_pick && ({1'b0, in_ch.operand_a[7:0]} >= 9'(count_q)))) begin
			dec_err = lesm_pkg::ERR_UNDER;
		end else if (((in_ch.opcode == lesm_pkg::OP_REGX) && (|in_ch.operand_a[63:5]))
			|| ((in_ch.opcode == lesm_pkg::OP_BREGX) && (|in_ch.operand_b[63:5]))) begin
			dec_err = lesm_pkg::ERR_BADREG;
		end else if (dec_push && (count_q >= CW'(STACK_DEPTH))) begin
			dec_err = lesm_pkg::ERR_OVER;
		end else if (((in_ch.opcode == lesm_pkg::OP_DIV) || (in_ch.opcode == lesm_pkg::OP_MOD))
			&& (top_q == 64'd0)) begin
			dec_err = lesm_pkg::ERR_DIVZ;
		end else begin
			dec_err = lesm_pkg::ERR_NONE;
		end
	end

	// register file read
	always_comb begin
		if (opc_q == lesm_pkg::OP_REGX) begin
			ridx = a_q[4:0];
		end else if (opc_q == lesm_pkg::OP_BREGX) begin
			ridx = b_q[4:0];
		end else begin
			ridx = opc_q[4:0] ^ 5'h10;
		end
		rval = (ridx == 5'd0) ? 64'd0 : {32'd0, rf_q[ridx]};
	end

	// shared alu
	always_comb begin
		slt_xy = $signed(x_q) < $signed(top_q);
		slt_yx = $signed(top_q) < $signed(x_q);
		case (opc_q) inside
			lesm_pkg::OP_ADDR, lesm_pkg::OP_CONST8U, lesm_pkg::OP_CONST8S: alu = a_q;
			lesm_pkg::OP_CONST1U: alu = {56'd0, a_q[7:0]};
			lesm_pkg::OP_CONST1S: alu = {{56{a_q[7]}}, a_q[7:0]};
			lesm_pkg::OP_CONST2U: alu = {48'd0, a_q[15:0]};
			lesm_pkg::OP_CONST2S: alu = {{48{a_q[15]}}, a_q[15:0]};
			lesm_pkg::OP_CONST4U: alu = {32'd0, a_q[31:0]};
			lesm_pkg::OP_CONST4S: alu = {{32{a_q[31]}}, a_q[31:0]};
			[lesm_pkg::OP_LIT_LO:lesm_pkg::OP_LIT_HI]: alu = 64'(opc_q - lesm_pkg::OP_LIT_LO);
			[lesm_pkg::OP_REG_LO:lesm_pkg::OP_REG_HI], lesm_pkg::OP_REGX: alu = rval;
			[lesm_pkg::OP_BREG_LO:lesm_pkg::OP_BREG_HI], lesm_pkg::OP_BREGX: alu = rval + a_q;
			lesm_pkg::OP_AND: alu = x_q & top_q;
			lesm_pkg::OP_MINUS: alu = x_q - top_q;
			lesm_pkg::OP_OR: alu = x_q | top_q;
			lesm_pkg::OP_PLUS: alu = x_q + top_q;
			lesm_pkg::OP_XOR: alu = x_q ^ top_q;
			lesm_pkg::OP_SHL: alu = (|top_q[63:6]) ? 64'd0 : (x_q << top_q[5:0]);
			lesm_pkg::OP_SHR: alu = (|top_q[63:6]) ? 64'd0 : (x_q >> top_q[5:0]);
			lesm_pkg::OP_SHRA: alu = (|top_q[63:6]) ? {64{x_q[63]}}
				: 64'($signed(x_q) >>> top_q[5:0]);
			lesm_pkg::OP_EQ: alu = {63'd0, x_q == top_q};
			lesm_pkg::OP_NE: alu = {63'd0, x_q != top_q};
			lesm_pkg::OP_GE: alu = {63'd0, !slt_xy};
			lesm_pkg::OP_GT: alu = {63'd0, slt_yx};
			lesm_pkg::OP_LE: alu = {63'd0, !slt_yx};
			lesm_pkg::OP_LT: alu = {63'd0, slt_xy};
			lesm_pkg::OP_ABS: alu = top_q[63] ? (64'd0 - top_q) : top_q;
			lesm_pkg::OP_NEG: alu = 64'd0 - top_q;
			lesm_pkg::OP_NOT: alu = ~top_q;
			lesm_pkg::OP_PLUS_UCONST: alu = top_q + a_q;
			lesm_pkg::OP_OVER, lesm_pkg::OP_PICK, lesm_pkg::OP_DROP, lesm_pkg::OP_SWAP,
			lesm_pkg::OP_ROT: alu = x_q;
			default: alu = top_q;
		endcase
	end

	always_comb begin
		case (psize_q)
			3'd1: reply_val = {56'd0, in_ch.read_data[7:0]};
			3'd2: reply_val = {48'd0, in_ch.read_data[15:0]};
			3'd3: reply_val = {40'd0, in_ch.read_data[23:0]};
			default: reply_val = {32'd0, in_ch.read_data};
		endcase
		case (cls_q)
			lesm_pkg::CLS_PUSH, lesm_pkg::CLS_UNARY, lesm_pkg::CLS_BIN: nwr = 2'd1;
			lesm_pkg::CLS_SWAP: nwr = 2'd2;
			lesm_pkg::CLS_ROT: nwr = 2'd3;
			default: nwr = 2'd0;
		endcase
		case (cnt_q[1:0])
			2'd0: begin
				mul_a = x_q[31:0];
				mul_b = top_q[31:0];
			end
			2'd1: begin
				mul_a = x_q[31:0];
				mul_b = top_q[63:32];
			end
			default: begin
				mul_a = x_q[63:32];
				mul_b = top_q[31:0];
			end
		endcase
		div_t = {rem_q, quo_q[63]};
		div_ge = div_t >= {1'b0, dvs_q};
	end

	// sequencer
	always_comb begin
		state_d = state_q;
		count_d = count_q;
		top_d = top_q;
		await_d = await_q;
		pfin_d = pfin_q;
		psize_d = psize_q;
		cnt_d = cnt_q;
		out_valid_d = out_valid_q && !out_ch.ready;
		okind_d = okind_q;
		oaddr_d = oaddr_q;
		obytes_d = obytes_q;
		oloc_d = oloc_q;
		oerr_d = oerr_q;
		opc_d = opc_q;
		a_d = a_q;
		b_d = b_q;
		last_d = last_q;
		cls_d = cls_q;
		need_d = need_q;
		x_d = x_q;
		z_d = z_q;
		res_d = res_q;
		acc_d = acc_q;
		prod_d = prod_q;
		quo_d = quo_q;
		rem_d = rem_q;
		dvs_d = dvs_q;
		rf_we = 1'b0;
		ram_we = 1'b0;
		ram_waddr = '0;
		ram_wdata = '0;
		ram_raddr = '0;

		unique case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					unique case (in_ch.operation)
						lesm_pkg::OPER_REGWR: begin
							rf_we = !(|in_ch.operand_b[63:5]);
						end
						lesm_pkg::OPER_REPLY: begin
							if (await_q) begin
								await_d = 1'b0;
								out_valid_d = 1'b1;
								oaddr_d = '0;
								obytes_d = '0;
								oloc_d = '0;
								oerr_d = lesm_pkg::ERR_NONE;
								if (!in_ch.read_ok || (count_q == '0)) begin
									okind_d = lesm_pkg::KIND_ERR;
									oerr_d = in_ch.read_ok ? lesm_pkg::ERR_UNDER
										: lesm_pkg::ERR_READ;
									count_d = '0;
									pfin_d = 1'b0;
									psize_d = '0;
								end else begin
									ram_we = 1'b1;
									ram_waddr = AW'(count_q - CW'(1));
									ram_wdata = reply_val;
									top_d = reply_val;
									psize_d = '0;
									out_valid_d = pfin_q;
									okind_d = lesm_pkg::KIND_LOC;
									oloc_d = reply_val[31:0];
									if (pfin_q) begin
										count_d = '0;
										pfin_d = 1'b0;
									end
								end
							end
						end
						lesm_pkg::OPER_EXPR: begin
							if (!await_q) begin
								oaddr_d = '0;
								obytes_d = '0;
								oloc_d = '0;
								oerr_d = lesm_pkg::ERR_NONE;
								if (dec_err != lesm_pkg::ERR_NONE) begin
									out_valid_d = 1'b1;
									okind_d = lesm_pkg::KIND_ERR;
									oerr_d = dec_err;
									count_d = '0;
									pfin_d = 1'b0;
									psize_d = '0;
								end else if (dec_cls == lesm_pkg::CLS_DEREF) begin
									out_valid_d = 1'b1;
									okind_d = lesm_pkg::KIND_READ;
									oaddr_d = top_q;
									obytes_d = dec_bytes;
									await_d = 1'b1;
									psize_d = dec_bytes;
									pfin_d = in_ch.last_op;
								end else begin
									opc_d = in_ch.opcode;
									a_d = in_ch.operand_a;
									b_d = in_ch.operand_b;
									last_d = in_ch.last_op;
									cls_d = dec_cls;
									need_d = dec_need;
									cnt_d = '0;
									state_d = (dec_need != 2'd0) ? S_FETCH : S_EXEC;
								end
							end
						end
						default: begin
						end
					endcase
				end
			end
			S_FETCH: begin
				if (cnt_q == 6'd0) begin
					ram_raddr = (opc_q == lesm_pkg::OP_PICK)
						? AW'(count_q - CW'(1) - CW'(a_q[7:0]))
						: AW'(count_q - CW'(2));
				end else begin
					ram_raddr = AW'(count_q - CW'(3));
				end
				if (cnt_q == 6'd1) begin
					x_d = ram_rdata;
				end
				if (cnt_q == 6'd2) begin
					z_d = ram_rdata;
				end
				cnt_d = cnt_q + 6'd1;
				if (cnt_q == {4'd0, need_q}) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				res_d = alu;
				cnt_d = '0;
				if (opc_q == lesm_pkg::OP_MUL) begin
					state_d = S_MUL;
				end else if ((opc_q == lesm_pkg::OP_DIV) || (opc_q == lesm_pkg::OP_MOD)) begin
					quo_d = ((opc_q == lesm_pkg::OP_DIV) && x_q[63]) ? (64'd0 - x_q) : x_q;
					dvs_d = ((opc_q == lesm_pkg::OP_DIV) && top_q[63]) ? (64'd0 - top_q) : top_q;
					rem_d = '0;
					state_d = S_DIV;
				end else begin
					state_d = S_WR;
				end
			end
			S_MUL: begin
				prod_d = 64'(mul_a) * 64'(mul_b);
				cnt_d = cnt_q + 6'd1;
				if (cnt_q == 6'd1) begin
					acc_d = prod_q;
				end else if (cnt_q == 6'd2) begin
					acc_d = acc_q + {prod_q[31:0], 32'd0};
				end else if (cnt_q == 6'd3) begin
					res_d = acc_q + {prod_q[31:0], 32'd0};
					cnt_d = '0;
					state_d = S_WR;
				end
			end
			S_DIV: begin
				rem_d = div_ge ? 64'(div_t - {1'b0, dvs_q}) : div_t[63:0];
				quo_d = {quo_q[62:0], div_ge};
				cnt_d = cnt_q + 6'd1;
				if (cnt_q == 6'd63) begin
					state_d = S_DFIN;
				end
			end
			S_DFIN: begin
				if (opc_q == lesm_pkg::OP_DIV) begin
					res_d = (x_q[63] ^ top_q[63]) ? (64'd0 - quo_q) : quo_q;
				end else begin
					res_d = rem_q;
				end
				cnt_d = '0;
				state_d = S_WR;
			end
			S_WR: begin
				ram_we = (cnt_q[1:0] < nwr);
				ram_wdata = res_q;
				ram_waddr = AW'(count_q - CW'(1) - CW'(cnt_q[1:0]));
				if (cls_q == lesm_pkg::CLS_PUSH) begin
					ram_waddr = AW'(count_q);
				end else if (cls_q == lesm_pkg::CLS_BIN) begin
					ram_waddr = AW'(count_q - CW'(2));
				end
				if ((cls_q == lesm_pkg::CLS_SWAP) && (cnt_q[1:0] == 2'd1)) begin
					ram_wdata = top_q;
				end
				if (cls_q == lesm_pkg::CLS_ROT) begin
					if (cnt_q[1:0] == 2'd1) begin
						ram_wdata = z_q;
					end else if (cnt_q[1:0] == 2'd2) begin
						ram_wdata = top_q;
					end
				end
				cnt_d = cnt_q + 6'd1;
				if ((nwr == 2'd0) || (cnt_q[1:0] == nwr - 2'd1)) begin
					state_d = S_IDLE;
					top_d = res_q;
					if (cls_q == lesm_pkg::CLS_PUSH) begin
						count_d = count_q + CW'(1);
					end else if ((cls_q == lesm_pkg::CLS_BIN) || (cls_q == lesm_pkg::CLS_DROP)) begin
						count_d = count_q - CW'(1);
					end
					if (last_q) begin
						out_valid_d = 1'b1;
						oaddr_d = '0;
						obytes_d = '0;
						oloc_d = '0;
						oerr_d = lesm_pkg::ERR_NONE;
						if (count_d == '0) begin
							okind_d = lesm_pkg::KIND_ERR;
							oerr_d = lesm_pkg::ERR_EMPTY;
						end else begin
							okind_d = lesm_pkg::KIND_LOC;
							oloc_d = res_q[31:0];
						end
						count_d = '0;
						await_d = 1'b0;
						pfin_d = 1'b0;
						psize_d = '0;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			await_q <= 1'b0;
			pfin_q <= 1'b0;
			psize_q <= '0;
			cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			await_q <= await_d;
			pfin_q <= pfin_d;
			psize_q <= psize_d;
			cnt_q <= cnt_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < lesm_pkg::REG_COUNT; i++) begin
				rf_q[i] <= '0;
			end
		end else if (rf_we) begin
			rf_q[in_ch.operand_b[4:0]] <= in_ch.operand_a[31:0];
		end
	end

	always_ff @(posedge clk) begin
		top_q <= top_d;
		okind_q <= okind_d;
		oaddr_q <= oaddr_d;
		obytes_q <= obytes_d;
		oloc_q <= oloc_d;
		oerr_q <= oerr_d;
		opc_q <= opc_d;
		a_q <= a_d;
		b_q <= b_d;
		last_q <= last_d;
		cls_q <= cls_d;
		need_q <= need_d;
		x_q <= x_d;
		z_q <= z_d;
		res_q <= res_d;
		acc_q <= acc_d;
		prod_q <= prod_d;
		quo_q <= quo_d;
		rem_q <= rem_d;
		dvs_q <= dvs_d;
	end

	`LESM_ASSERT_IMPL(a_await_idle, clk, arst_n, await_q, state_q == S_IDLE)
	`LESM_ASSERT(a_count_range, clk, arst_n, count_q <= CW'(STACK_DEPTH))
	`LESM_ASSERT_IMPL(a_busy_no_out, clk, arst_n, state_q != S_IDLE, !out_valid_q)
	`LESM_ASSERT_IMPL(a_req_await, clk, arst_n, out_valid_q && (okind_q == lesm_pkg::KIND_READ), await_q)
endmodule

FILE: test/lesm_tb_if.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lesm_tb_if
// item and result types of the testbench; the channel interfaces come from rtl
// ----------------------------------------------------------------------------
package lesm_tb_pkg;
	import lesm_pkg::*;

	typedef struct packed {
		logic [1:0]  operation;
		logic [7:0]  opcode;
		logic [63:0] operand_a;
		logic [63:0] operand_b;
		logic        last_op;
		logic [31:0] read_data;
		logic        read_ok;
	} item_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [63:0] read_address;
		logic [2:0]  read_bytes;
		logic [31:0] location;
		logic [2:0]  error_code;
	} result_t;
endpackage

FILE: test/tb_location_expression_stack_machine.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_location_expression_stack_machine
// runs directed and random operator, reply and register write items through
// the stack machine and checks every result against a built-in predictor
// ----------------------------------------------------------------------------
module tb_location_expression_stack_machine;
	import lesm_pkg::*;
	import lesm_tb_pkg::*;

	localparam int LIMIT = 600000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	lesm_in_if  in_ch();
	lesm_out_if out_ch();

	location_expression_stack_machine DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch.sink),
		.out_ch (out_ch.source)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predictor state
	logic [63:0] vstack [16];
	int          vcount;
	logic [31:0] regs [32];
	bit          await_rd;
	bit          pend_final;
	int          pend_size;

	item_t   pending_items [$];
	result_t expected_results [$];
	int      mismatches;
	int      cycles;
	bit      stim_done;
	int      gap;
	int      out_stall;

	function automatic result_t mk(logic [1:0] k, logic [63:0] ad, logic [2:0] by,
			logic [31:0] lc, logic [2:0] er);
		result_t r;
		r.kind = k; r.read_address = ad; r.read_bytes = by;
		r.location = lc; r.error_code = er;
		return r;
	endfunction

	function automatic void add_expect(result_t r);
		expected_results.insert(expected_results.size(), r);
	endfunction

	function automatic bit slt(logic [63:0] x, logic [63:0] y);
		return $signed(x) < $signed(y);
	endfunction

	function automatic logic [63:0] rd_reg(logic [63:0] n);
		if (n == 0 || n > 31)
			return 64'd0;
		return {32'd0, regs[n[4:0]]};
	endfunction

	function automatic void emit_error(logic [2:0] code);
		vcount = 0; await_rd = 0; pend_final = 0; pend_size = 0;
		add_expect(mk(KIND_ERR, 0, 0, 0, code));
	endfunction

	function automatic void emit_final();
		if (vcount == 0) begin
			emit_error(ERR_EMPTY);
			return;
		end
		add_expect(mk(KIND_LOC, 0, 0, vstack[vcount - 1][31:0], ERR_NONE));
		vcount = 0; await_rd = 0; pend_final = 0; pend_size = 0;
	endfunction

	function automatic logic [2:0] run_op(logic [7:0] opc, logic [63:0] a, logic [63:0] b,
			output int req);
		int          n;
		logic [63:0] p, t, x, y, mx, my;
		bit          has_push;
		int          idx;
		n = vcount; has_push = 1; p = 0; req = 0;
		if (opc == OP_ADDR || opc == OP_CONST8U || opc == OP_CONST8S) p = a;
		else if (opc == OP_CONST1U) p = {56'd0, a[7:0]};
		else if (opc == OP_CONST1S) p = {{56{a[7]}}, a[7:0]};
		else if (opc == OP_CONST2U) p = {48'd0, a[15:0]};
		else if (opc == OP_CONST2S) p = {{48{a[15]}}, a[15:0]};
		else if (opc == OP_CONST4U) p = {32'd0, a[31:0]};
		else if (opc == OP_CONST4S) p = {{32{a[31]}}, a[31:0]};
		else if (opc >= OP_LIT_LO && opc <= OP_LIT_HI) p = opc - OP_LIT_LO;
		else if (opc >= OP_REG_LO && opc <= OP_REG_HI) p = rd_reg(opc - OP_REG_LO);
		else if (opc >= OP_BREG_LO && opc <= OP_BREG_HI) p = rd_reg(opc - OP_BREG_LO) + a;
		else if (opc == OP_REGX) begin
			if (a > 31) return ERR_BADREG;
			p = rd_reg(a);
		end else if (opc == OP_BREGX) begin
			if (b > 31) return ERR_BADREG;
			p = rd_reg(b) + a;
		end else if (opc == OP_DUP) begin
			if (n < 1) return ERR_UNDER;
			p = vstack[n - 1];
		end else if (opc == OP_OVER) begin
			if (n < 2) return ERR_UNDER;
			p = vstack[n - 2];
		end else if (opc == OP_PICK) begin
			idx = a[7:0];
			if (idx >= n) return ERR_UNDER;
			p = vstack[n - 1 - idx];
		end else has_push = 0;
		if (has_push) begin
			if (n >= 16) return ERR_OVER;
			vstack[n] = p; vcount = n + 1;
			return ERR_NONE;
		end
		if ((opc >= OP_AND && opc <= OP_MUL) || opc == OP_OR || opc == OP_PLUS ||
				(opc >= OP_SHL && opc <= OP_XOR) || (opc >= OP_EQ && opc <= OP_NE)) begin
			if (n < 2) return ERR_UNDER;
			x = vstack[n - 2]; y = vstack[n - 1];
			case (opc)
				OP_AND: t = x & y;
				OP_DIV: begin
					if (y == 0) return ERR_DIVZ;
					mx = x[63] ? -x : x; my = y[63] ? -y : y;
					t = mx / my;
					if (x[63] != y[63]) t = -t;
				end
				OP_MINUS: t = x - y;
				OP_MOD: begin
					if (y == 0) return ERR_DIVZ;
					t = x % y;
				end
				OP_MUL: t = x * y;
				OP_OR: t = x | y;
				OP_PLUS: t = x + y;
				OP_SHL: t = (y >= 64) ? 0 : x << y[5:0];
				OP_SHR: t = (y >= 64) ? 0 : x >> y[5:0];
				OP_SHRA: begin
					if (y >= 64) t = {64{x[63]}};
					else t = $signed(x) >>> y[5:0];
				end
				OP_XOR: t = x ^ y;
				OP_EQ: t = (x == y);
				OP_GE: t = !slt(x, y);
				OP_GT: t = slt(y, x);
				OP_LE: t = !slt(y, x);
				OP_LT: t = slt(x, y);
				default: t = (x != y);
			endcase
			vstack[n - 2] = t; vcount = n - 1;
			return ERR_NONE;
		end
		case (opc)
			OP_SKIP, OP_NOP: return ERR_NONE;
			OP_DEREF, OP_DEREF_SIZE: begin
				if (opc == OP_DEREF_SIZE && (a < 1 || a > 4)) return ERR_UNSUP;
				if (n < 1) return ERR_UNDER;
				req = (opc == OP_DEREF) ? 4 : int'(a[2:0]);
				return ERR_NONE;
			end
			OP_DROP, OP_ABS, OP_NEG, OP_NOT, OP_PLUS_UCONST: begin
				if (n < 1) return ERR_UNDER;
				t = vstack[n - 1];
				case (opc)
					OP_DROP: vcount = n - 1;
					OP_ABS: vstack[n - 1] = t[63] ? -t : t;
					OP_NEG: vstack[n - 1] = -t;
					OP_NOT: vstack[n - 1] = ~t;
					default: vstack[n - 1] = t + a;
				endcase
				return ERR_NONE;
			end
			OP_SWAP: begin
				if (n < 2) return ERR_UNDER;
				t = vstack[n - 1]; vstack[n - 1] = vstack[n - 2]; vstack[n - 2] = t;
				return ERR_NONE;
			end
			OP_ROT: begin
				if (n < 3) return ERR_UNDER;
				t = vstack[n - 1]; vstack[n - 1] = vstack[n - 2];
				vstack[n - 2] = vstack[n - 3]; vstack[n - 3] = t;
				return ERR_NONE;
			end
			default: return ERR_UNSUP;
		endcase
	endfunction

	function automatic void predict(item_t it);
		logic [2:0]  e;
		int          req;
		logic [31:0] mask;
		if (it.operation == OPER_REGWR) begin
			if (it.operand_b < 32) regs[it.operand_b[4:0]] = it.operand_a[31:0];
			return;
		end
		if (it.operation == OPER_REPLY) begin
			if (!await_rd) return;
			await_rd = 0;
			if (!it.read_ok) begin
				emit_error(ERR_READ);
				return;
			end
			if (vcount == 0) begin
				emit_error(ERR_UNDER);
				return;
			end
			mask = (pend_size >= 1 && pend_size < 4) ? (32'd1 << (8 * pend_size)) - 1
				: 32'hFFFFFFFF;
			vstack[vcount - 1] = {32'd0, it.read_data & mask};
			pend_size = 0;
			if (pend_final) emit_final();
			return;
		end
		if (it.operation != OPER_EXPR || await_rd) return;
		e = run_op(it.opcode, it.operand_a, it.operand_b, req);
		if (e != ERR_NONE) begin
			emit_error(e);
			return;
		end
		if (req != 0) begin
			await_rd = 1; pend_size = req; pend_final = it.last_op;
			add_expect(mk(KIND_READ, vstack[vcount - 1], req, 0, ERR_NONE));
			return;
		end
		if (it.last_op) emit_final();
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic logic [63:0] rnd64();
		case ($urandom_range(0, 5))
			0: return 64'd0;
			1: return '1;
			2: return 64'h8000000000000000;
			3: return $urandom_range(0, 70);
			default: return {$urandom, $urandom};
		endcase
	endfunction

	function automatic item_t mk_item(logic [1:0] oper, logic [7:0] opc, logic [63:0] a,
			logic [63:0] b, logic lst);
		item_t it;
		it.operation = oper; it.opcode = opc; it.operand_a = a; it.operand_b = b;
		it.last_op = lst; it.read_data = $urandom; it.read_ok = 1'b1;
		return it;
	endfunction

	function automatic void add_item(item_t it);
		pending_items.insert(pending_items.size(), it);
	endfunction

	function automatic logic [7:0] rnd_opcode();
		logic [7:0] ops [$];
		ops = '{OP_ADDR, OP_CONST1U, OP_CONST1S, OP_CONST2U, OP_CONST2S, OP_CONST4U,
			OP_CONST4S, OP_CONST8U, OP_CONST8S, OP_DUP, OP_DROP, OP_OVER, OP_PICK,
			OP_SWAP, OP_ROT, OP_ABS, OP_AND, OP_DIV, OP_MINUS, OP_MOD, OP_MUL, OP_NEG,
			OP_NOT, OP_OR, OP_PLUS, OP_PLUS_UCONST, OP_SHL, OP_SHR, OP_SHRA, OP_XOR,
			OP_EQ, OP_GE, OP_GT, OP_LE, OP_LT, OP_NE, OP_SKIP, OP_NOP, OP_REGX,
			OP_BREGX, OP_DEREF, OP_DEREF_SIZE};
		case ($urandom_range(0, 9))
			0: return $urandom_range(OP_LIT_LO, OP_LIT_HI);
			1: return $urandom_range(OP_REG_LO, OP_BREG_HI);
			2: return $urandom_range(0, 255);
			default: return ops[$urandom_range(0, ops.size() - 1)];
		endcase
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			gap <= 0;
		end else if (!in_ch.valid || in_ch.ready) begin
			if (in_ch.valid) predict(pending_items.pop_front());
			if (gap > 0 || pending_items.size() == 0) begin
				in_ch.valid <= 1'b0;
				if (gap > 0) gap <= gap - 1;
			end else begin
				in_ch.valid <= 1'b1;
				in_ch.operation <= pending_items[0].operation;
				in_ch.opcode <= pending_items[0].opcode;
				in_ch.operand_a <= pending_items[0].operand_a;
				in_ch.operand_b <= pending_items[0].operand_b;
				in_ch.last_op <= pending_items[0].last_op;
				in_ch.read_data <= pending_items[0].read_data;
				in_ch.read_ok <= pending_items[0].read_ok;
				gap <= pick_gap();
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		result_t got, want;
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			out_stall <= 0;
		end else begin
			cycles <= cycles + 1;
			if (out_ch.valid && out_ch.ready) begin
				got = mk(out_ch.kind, out_ch.read_address, out_ch.read_bytes,
					out_ch.location, out_ch.error_code);
				if (expected_results.size() == 0) begin
					mismatches <= mismatches + 1;
					if (mismatches < 10)
						$display("unexpected transfer: kind %0d err %0d", got.kind,
							got.error_code);
				end else begin
					want = expected_results.pop_front();
					if (got != want) begin
						mismatches <= mismatches + 1;
						if (mismatches < 10) begin
							$write("mismatch: exp kind %0d addr %h bytes %0d loc %h err %0d,",
								want.kind, want.read_address, want.read_bytes, want.location,
								want.error_code);
							$display(" got kind %0d addr %h bytes %0d loc %h err %0d",
								got.kind, got.read_address, got.read_bytes,
								got.location, got.error_code);
						end
					end
				end
			end
			if (out_stall > 0) begin
				out_ch.ready <= 1'b0;
				out_stall <= out_stall - 1;
			end else begin
				out_ch.ready <= 1'b1;
				out_stall <= ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
			end
		end
	end

	initial begin
		int          i;
		logic [63:0] a;
		for (i = 0; i < 32; i++) regs[i] = 0;
		vcount = 0; await_rd = 0; pend_final = 0; pend_size = 0;
		mismatches = 0; cycles = 0; stim_done = 0;
		in_ch.operation = 0; in_ch.opcode = 0; in_ch.operand_a = 0; in_ch.operand_b = 0;
		in_ch.last_op = 0; in_ch.read_data = 0; in_ch.read_ok = 0; in_ch.valid = 0;
		out_ch.ready = 0;
		// directed part
		add_item(mk_item(OPER_EXPR, OP_NOP, 0, 0, 1));
		add_item(mk_item(OPER_EXPR, OP_DROP, 0, 0, 0));
		add_item(mk_item(OPER_REGWR, 0, 64'hFFFFFFFFFFFFFFFF, 31, 0));
		add_item(mk_item(OPER_REGWR, 0, 64'h12345678, 0, 0));
		add_item(mk_item(OPER_REGWR, 0, 64'h5, 64'hFFFFFFFFFFFFFFFF, 0));
		add_item(mk_item(OPER_EXPR, OP_REG_LO, 0, 0, 0));
		add_item(mk_item(OPER_EXPR, OP_BREGX, 64'hFFFFFFFFFFFFFFFF, 31, 0));
		add_item(mk_item(OPER_EXPR, OP_REGX, 32, 0, 0));
		add_item(mk_item(OPER_EXPR, OP_CONST8S, 64'h8000000000000000, 0, 0));
		add_item(mk_item(OPER_EXPR, OP_CONST1S, 64'hFF, 0, 0));
		add_item(mk_item(OPER_EXPR, OP_DIV, 0, 0, 0));
		add_item(mk_item(OPER_EXPR, OP_LIT_LO, 0, 0, 0));
		add_item(mk_item(OPER_EXPR, OP_MOD, 0, 0, 0));
		add_item(mk_item(OPER_EXPR, OP_LIT_HI, 0, 0, 0));
		add_item(mk_item(OPER_EXPR, OP_DEREF_SIZE, 5, 0, 0));
		add_item(mk_item(OPER_REPLY, 0, 0, 0, 0));
		add_item(mk_item(OPER_EXPR, OP_LIT_HI, 0, 0, 0));
		add_item(mk_item(OPER_EXPR, OP_DEREF_SIZE, 2, 0, 1));
		add_item(mk_item(OPER_EXPR, OP_LIT_LO, 0, 0, 0));
		add_item(mk_item(OPER_REPLY, 0, 0, 0, 0));
		add_item(mk_item(OPER_EXPR, OP_CONST4U, 64'h100, 0, 0));
		add_item(mk_item(OPER_EXPR, OP_DEREF, 0, 0, 0));
		pending_items[$].read_ok = 0;
		add_item(mk_item(3, OP_LIT_LO, 0, 0, 1));
		for (i = 0; i < 17; i++) add_item(mk_item(OPER_EXPR, OP_LIT_LO + 1, 0, 0, 0));
		add_item(mk_item(OPER_EXPR, OP_PICK, 0, 0, 1));
		// random part: mostly well-formed expressions
		for (i = 0; i < 780; i++) begin
			case ($urandom_range(0, 19))
				0: add_item(mk_item(OPER_REGWR, 0, rnd64(), $urandom_range(0, 40), 0));
				1: add_item(mk_item(OPER_REPLY, 0, 0, 0, 0));
				2: add_item(mk_item($urandom_range(0, 3), $urandom, rnd64(), rnd64(),
					$urandom_range(0, 1)));
				default: begin
					a = rnd64();
					if ($urandom_range(0, 3) == 0) a = $urandom_range(0, 6);
					add_item(mk_item(OPER_EXPR, rnd_opcode(), a,
						($urandom_range(0, 3) == 0) ? rnd64() : $urandom_range(0, 31),
						$urandom_range(0, 9) == 0));
					pending_items[$].read_ok = $urandom_range(0, 9) != 0;
					if (pending_items[$].opcode == OP_DEREF ||
							pending_items[$].opcode == OP_DEREF_SIZE)
						add_item(mk_item(OPER_REPLY, 0, 0, 0, 0));
					pending_items[$].read_ok = $urandom_range(0, 9) != 0;
				end
			endcase
		end
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		wait (pending_items.size() == 0);
		wait (expected_results.size() == 0);
		repeat (100) @(posedge clk);
		stim_done = 1;
	end

	initial begin
		wait (stim_done || cycles >= LIMIT);
		if (stim_done && mismatches == 0 && expected_results.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

FILE: location_expression_stack_machine.f
+incdir+rtl/core
rtl/core/lesm_pkg.sv
rtl/core/lesm_in_if.sv
rtl/core/lesm_out_if.sv
rtl/core/lesm_ram.sv
rtl/core/location_expression_stack_machine.sv
test/lesm_tb_if.sv
test/tb_location_expression_stack_machine.sv
